### rtl/core/pol_pkg.sv
// Shared types and codes for the positional ordered list.
// Operation, status and cell command codes, plus default sizes.
// No dependencies.
package pol_pkg;

   // Default sizes handed to the top level parameters
   localparam int DEPTH_DEF = 16;
   localparam int WIDTH_DEF = 32;

   // Fixed field widths of the stream payloads
   localparam int OP_W    = 2;
   localparam int POS_W   = 5;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   // Padded stream widths (whole bytes)
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // What every cell does in a cycle
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_PUT    = 2'd1,
      CELL_INSERT = 2'd2,
      CELL_DELETE = 2'd3
   } cell_mode_type;

   typedef struct packed {
      logic          update;
      cell_mode_type mode;
   } cell_cmd_type;

endpackage

### rtl/core/pol_cell.sv
// One storage cell of the positional ordered list.
// Holds one entry and takes a neighbour's entry on insert and delete.
// Depends on pol_pkg.
module pol_cell #(
   parameter int IDX   = 0,
   parameter int DEPTH = pol_pkg::DEPTH_DEF,
   parameter int WIDTH = pol_pkg::WIDTH_DEF,
   parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  pol_pkg::cell_cmd_type cmd,
   input  logic [IDX_W-1:0]      target_idx,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [WIDTH-1:0]      left_data,   // entry of the cell one place lower
   input  logic [WIDTH-1:0]      right_data,  // entry of the cell one place higher
   output logic [WIDTH-1:0]      entry
);
   import pol_pkg::*;

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // Next entry: load, take from left (opening a gap) or from right (closing one)
   always_comb begin
      data_in = data_ff;
      if (cmd.update) begin
         case (cmd.mode)
            CELL_PUT: begin
               if (MY_IDX == target_idx) data_in = wr_data;
            end
            CELL_INSERT: begin
               if (MY_IDX == target_idx) data_in = wr_data;
               else if (MY_IDX > target_idx) data_in = left_data;
            end
            CELL_DELETE: begin
               if (MY_IDX >= target_idx) data_in = right_data;
            end
            default: begin
               data_in = data_ff;
            end
         endcase
      end
   end

   // Payload only, no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign entry = data_ff;

endmodule

### rtl/core/positional_ordered_list_unit.sv
// Positional ordered list: append, insert, delete and read by position.
// Response: registered, and valid in the cycle after the request transfer.
// Throughput: one request per cycle while responses are taken; the chain of cells shifts the
// affected entries in the same cycle, so an insert or delete costs no more than an append.
// Reset: synchronous, active high; empties the list and drops any pending response.
module positional_ordered_list_unit #(
   parameter int DEPTH = pol_pkg::DEPTH_DEF,
   parameter int WIDTH = pol_pkg::WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [4:0] position, [36:5] value, [39:37] zero
   input  logic [pol_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] operation
   input  logic [pol_pkg::OP_W-1:0]       req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [31:0] read_value, [36:32] entry_count, [39:37] zero
   output logic [pol_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] status
   output logic [pol_pkg::STAT_W-1:0]     rsp_tuser
);
   import pol_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CMP_W-1:0] FULL_CNT = CMP_W'(DEPTH);

   // Request fields
   op_type             req_op;
   logic [POS_W-1:0]   req_pos;
   logic [VALUE_W-1:0] req_value;
   logic               accept;

   // Control and response registers
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               rsp_valid_ff;
   status_type         status_ff;
   status_type         status_in;
   logic [VALUE_W-1:0] read_ff;
   logic [VALUE_W-1:0] read_in;
   logic [COUNT_W-1:0] rsp_count_ff;

   // Decode helpers
   logic [CMP_W-1:0]   cnt_ext;
   logic [CMP_W-1:0]   pos_ext;
   logic [CMP_W-1:0]   pos_m1;
   logic               pos_ok;
   logic               full;
   logic [63:0]        value_ext;
   logic [WIDTH-1:0]   wr_data;
   logic [63:0]        rd_ext;
   logic [IDX_W-1:0]   target_idx;
   cell_cmd_type       cmd;

   logic [WIDTH-1:0]   cell_q [DEPTH];

   assign req_op    = op_type'(req_tuser);
   assign req_pos   = req_tdata[POS_W-1:0];
   assign req_value = req_tdata[POS_W+VALUE_W-1:POS_W];

   // Output register frees the input side once the response is taken
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign cnt_ext   = CMP_W'(count_ff);
   assign pos_ext   = CMP_W'(req_pos);
   assign pos_m1    = pos_ext - CMP_W'(1);
   assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
   assign full      = (cnt_ext == FULL_CNT);
   assign value_ext = 64'(req_value);
   assign wr_data   = value_ext[WIDTH-1:0];
   assign rd_ext    = 64'(cell_q[pos_m1[IDX_W-1:0]]);

   // Operation decode: status, cell command and next count
   always_comb begin
      status_in  = ST_DONE;
      read_in    = '0;
      count_in   = count_ff;
      cmd.update = 1'b0;
      cmd.mode   = CELL_HOLD;
      target_idx = pos_m1[IDX_W-1:0];
      case (req_op)
         OP_APPEND: begin
            target_idx = cnt_ext[IDX_W-1:0];
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.mode = CELL_PUT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_INSERT: begin
            if (!pos_ok) begin
               status_in = ST_RANGE;
            end else if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.mode = CELL_INSERT;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_DELETE: begin
            if (!pos_ok) begin
               status_in = ST_RANGE;
            end else begin
               cmd.mode = CELL_DELETE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_READ: begin
            if (!pos_ok) status_in = ST_RANGE;
            else read_in = rd_ext[VALUE_W-1:0];
         end
         default: begin
            status_in = ST_DONE;
         end
      endcase
      if (!accept) begin
         cmd.mode = CELL_HOLD;
         count_in = count_ff;
      end
      cmd.update = accept && (cmd.mode != CELL_HOLD);
   end

   // Row of cells, each linked to its neighbours
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      logic [WIDTH-1:0] left_data;
      logic [WIDTH-1:0] right_data;

      if (k == 0) begin : g_first
         assign left_data = cell_q[k];
      end else begin : g_mid_lo
         assign left_data = cell_q[k-1];
      end
      if (k == DEPTH - 1) begin : g_last
         assign right_data = cell_q[k];
      end else begin : g_mid_hi
         assign right_data = cell_q[k+1];
      end

      pol_cell #(
         .IDX   (k),
         .DEPTH (DEPTH),
         .WIDTH (WIDTH),
         .IDX_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .target_idx (target_idx),
         .wr_data    (wr_data),
         .left_data  (left_data),
         .right_data (right_data),
         .entry      (cell_q[k])
      );
   end

   // Count and response handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload, loaded on each request transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         read_ff      <= read_in;
         rsp_count_ff <= COUNT_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - VALUE_W - COUNT_W)'(0), rsp_count_ff, read_ff};

endmodule
